// ===== rtl/core/rqfh_pkg.sv =====
`default_nettype none
package rqfh_pkg;

  localparam int COORD_W   = 24;
  localparam int DIFF_W    = 25;
  localparam int CROSS_W   = 51;
  localparam int LO_W      = 26;
  localparam int HI_W      = CROSS_W - LO_W;
  localparam int MUL_B_W   = 27;
  localparam int PROD_W    = DIFF_W + MUL_B_W;
  localparam int ACC_W     = 80;
  localparam int NUM_CORNER_COORDS = 9;

  localparam logic [1:0] LAST_COMP      = 2'd2;
  localparam logic [1:0] LAST_CROSS_GRP = 2'd1;
  localparam logic [1:0] LAST_DOT_GRP   = 2'd3;

  localparam logic [1:0] GRP_P   = 2'd0;
  localparam logic [1:0] GRP_DET = 2'd0;
  localparam logic [1:0] GRP_UN  = 2'd1;
  localparam logic [1:0] GRP_VN  = 2'd2;
  localparam logic [1:0] GRP_TN  = 2'd3;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [7:0]                screen_id;
    logic signed [COORD_W-1:0] vec_a_x;
    logic signed [COORD_W-1:0] vec_a_y;
    logic signed [COORD_W-1:0] vec_a_z;
    logic signed [COORD_W-1:0] vec_b_x;
    logic signed [COORD_W-1:0] vec_b_y;
    logic signed [COORD_W-1:0] vec_b_z;
    logic signed [COORD_W-1:0] vec_c_x;
    logic signed [COORD_W-1:0] vec_c_y;
    logic signed [COORD_W-1:0] vec_c_z;
  } req_t;

  typedef struct packed {
    logic       success;
    logic [7:0] hit_id;
    logic [1:0] status;
  } res_t;

  typedef logic [NUM_CORNER_COORDS-1:0][COORD_W-1:0] corners_t;

  typedef struct packed {
    logic       latch;
    logic       rd;
    logic       chk;
    logic       load;
    logic       mac;
    logic       dec;
    logic       fin;
    logic       phase_dot;
    logic [1:0] grp;
    logic [1:0] comp;
    logic       half;
  } cmd_t;

  typedef struct packed {
    logic start_clear;
    logic want_compute;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rqfh_ctrl.sv =====
`default_nettype none
module rqfh_ctrl #(
  parameter int MAX_SCREENS = 8,
  parameter int IDX_W = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rqfh_pkg::sts_t    sts,
  output rqfh_pkg::cmd_t         cmd,
  output logic [IDX_W-1:0]       idx
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_MAC  = 7'b0010000,
    S_DEC  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SCREENS - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic       phase_r, phase_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       half_r, half_nxt;
  logic       last_slot;

  assign last_slot = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    comp_nxt  = comp_r;
    half_nxt  = half_r;
    cmd       = '0;
    cmd.phase_dot = phase_r;
    cmd.grp   = grp_r;
    cmd.comp  = comp_r;
    cmd.half  = half_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          idx_nxt   = '0;
          state_nxt = sts.start_clear ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.want_compute) begin
          state_nxt = S_LOAD;
        end else if (last_slot) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        phase_nxt = 1'b0;
        grp_nxt   = '0;
        comp_nxt  = '0;
        half_nxt  = 1'b0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac  = 1'b1;
        half_nxt = ~half_r;
        if (half_r) begin
          if (comp_r == rqfh_pkg::LAST_COMP) begin
            comp_nxt = '0;
            if (!phase_r && grp_r == rqfh_pkg::LAST_CROSS_GRP) begin
              phase_nxt = 1'b1;
              grp_nxt   = '0;
            end else if (phase_r && grp_r == rqfh_pkg::LAST_DOT_GRP) begin
              state_nxt = S_DEC;
            end else begin
              grp_nxt = grp_r + 1'b1;
            end
          end else begin
            comp_nxt = comp_r + 1'b1;
          end
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (last_slot) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      phase_r <= 1'b0;
      grp_r   <= '0;
      comp_r  <= '0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      grp_r   <= grp_nxt;
      comp_r  <= comp_nxt;
      half_r  <= half_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

endmodule
`default_nettype wire

// ===== rtl/core/rqfh_dp.sv =====
`default_nettype none
module rqfh_dp #(
  parameter int MAX_SCREENS = 8,
  parameter int IDX_W = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rqfh_pkg::req_t    in_req,
  input  wire rqfh_pkg::cmd_t    cmd,
  input  wire logic [IDX_W-1:0]  idx,
  output rqfh_pkg::sts_t         sts,
  output logic                   out_valid,
  output rqfh_pkg::res_t         out_res
);

  localparam int DW = rqfh_pkg::DIFF_W;
  localparam int CW = rqfh_pkg::CROSS_W;
  localparam int AW = rqfh_pkg::ACC_W;
  localparam int BW = rqfh_pkg::MUL_B_W;
  localparam int PW = rqfh_pkg::PROD_W;
  localparam int LW = rqfh_pkg::LO_W;

  function automatic logic [1:0] next3(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sx(input logic [rqfh_pkg::COORD_W-1:0] v);
    return DW'($signed(v));
  endfunction

  rqfh_pkg::corners_t corner_mem [MAX_SCREENS];
  logic [7:0]         id_mem     [MAX_SCREENS];
  rqfh_pkg::corners_t rd_corner_r;
  logic [7:0]         rd_id_r;

  rqfh_pkg::req_t   req_r;
  logic [MAX_SCREENS-1:0] valid_r;
  logic             dup_r, free_found_r, found_r, best_v_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [7:0]       best_r;

  logic [2:0][DW-1:0] ea_r, eb_r, s_r;
  logic [2:0][CW-1:0] p_r, q_r;
  logic signed [AW-1:0] acc_r, det_r, un_r, vn_r, tn_r;

  logic [2:0][DW-1:0] d_v;
  logic               is_match, is_less;
  logic               out_valid_r;
  rqfh_pkg::res_t     res_r, res_nxt;

  assign d_v[0] = sx(req_r.vec_b_x);
  assign d_v[1] = sx(req_r.vec_b_y);
  assign d_v[2] = sx(req_r.vec_b_z);

  assign is_match = valid_r[idx] && (rd_id_r == req_r.screen_id);
  assign is_less  = !best_v_r || (rd_id_r < best_r);

  assign sts.start_clear  = (in_req.req_type == rqfh_pkg::REQ_CLEAR);
  assign sts.want_compute = (req_r.req_type == rqfh_pkg::REQ_QUERY) && valid_r[idx] && is_less;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_corner_r <= corner_mem[idx];
      rd_id_r     <= id_mem[idx];
    end
    if (cmd.fin && req_r.req_type == rqfh_pkg::REQ_ADD && !dup_r && free_found_r) begin
      corner_mem[free_idx_r] <= {req_r.vec_c_z, req_r.vec_c_y, req_r.vec_c_x,
                                 req_r.vec_b_z, req_r.vec_b_y, req_r.vec_b_x,
                                 req_r.vec_a_z, req_r.vec_a_y, req_r.vec_a_x};
      id_mem[free_idx_r] <= req_r.screen_id;
    end
  end

  logic [1:0] c, i1, i2;
  logic [2:0][DW-1:0] xc, yc, xd;
  logic [2:0][CW-1:0] yd;
  logic signed [DW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] term, acc_nxt;
  logic                 first;

  always_comb begin
    c  = cmd.comp;
    i1 = next3(c);
    i2 = next3(i1);
    xc = (cmd.grp == rqfh_pkg::GRP_P) ? d_v : s_r;
    yc = (cmd.grp == rqfh_pkg::GRP_P) ? eb_r : ea_r;
    case (cmd.grp)
      rqfh_pkg::GRP_DET: xd = ea_r;
      rqfh_pkg::GRP_UN:  xd = s_r;
      rqfh_pkg::GRP_VN:  xd = d_v;
      default:           xd = eb_r;
    endcase
    yd = (cmd.grp == rqfh_pkg::GRP_DET || cmd.grp == rqfh_pkg::GRP_UN) ? p_r : q_r;
    if (!cmd.phase_dot) begin
      op_a = cmd.half ? xc[i2] : xc[i1];
      op_b = BW'($signed(cmd.half ? yc[i1] : yc[i2]));
    end else begin
      op_a = xd[c];
      op_b = cmd.half ? BW'($signed(yd[c][CW-1:LW])) : $signed({1'b0, yd[c][LW-1:0]});
    end
    prod = op_a * op_b;
    term = AW'(prod);
    if (cmd.phase_dot && cmd.half) begin
      term = term <<< LW;
    end
    if (!cmd.phase_dot && cmd.half) begin
      term = -term;
    end
    first   = cmd.phase_dot ? (c == 2'd0 && !cmd.half) : !cmd.half;
    acc_nxt = (first ? '0 : acc_r) + term;
  end

  logic det_zero, det_neg, hit;
  always_comb begin
    det_zero = (det_r == '0);
    det_neg  = det_r[AW-1];
    if (det_neg) begin
      hit = (tn_r <= 0) && (un_r <= 0) && (vn_r <= 0) && (un_r >= det_r) && (vn_r >= det_r);
    end else begin
      hit = (tn_r >= 0) && (un_r >= 0) && (vn_r >= 0) && (un_r <= det_r) && (vn_r <= det_r);
    end
    hit = hit && !det_zero;
  end

  always_comb begin
    res_nxt = '0;
    case (req_r.req_type)
      rqfh_pkg::REQ_ADD: begin
        if (dup_r) begin
          res_nxt.status = rqfh_pkg::ST_DUPLICATE;
        end else if (!free_found_r) begin
          res_nxt.status = rqfh_pkg::ST_FULL;
        end else begin
          res_nxt.success = 1'b1;
        end
      end
      rqfh_pkg::REQ_REMOVE: begin
        res_nxt.success = found_r;
        res_nxt.status  = found_r ? rqfh_pkg::ST_OK : rqfh_pkg::ST_NOT_FOUND;
      end
      rqfh_pkg::REQ_CLEAR: begin
        res_nxt.success = 1'b1;
      end
      default: begin
        res_nxt.success = best_v_r;
        res_nxt.hit_id  = best_v_r ? best_r : 8'd0;
        res_nxt.status  = best_v_r ? rqfh_pkg::ST_OK : rqfh_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
    end
    if (cmd.chk && !valid_r[idx] && !free_found_r) begin
      free_idx_r <= idx;
    end
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        ea_r[k] <= sx(rd_corner_r[3+k]) - sx(rd_corner_r[k]);
        eb_r[k] <= sx(rd_corner_r[6+k]) - sx(rd_corner_r[k]);
      end
      s_r[0] <= sx(req_r.vec_a_x) - sx(rd_corner_r[0]);
      s_r[1] <= sx(req_r.vec_a_y) - sx(rd_corner_r[1]);
      s_r[2] <= sx(req_r.vec_a_z) - sx(rd_corner_r[2]);
    end
    if (cmd.mac) begin
      acc_r <= acc_nxt;
      if (!cmd.phase_dot && cmd.half) begin
        if (cmd.grp == rqfh_pkg::GRP_P) begin
          p_r[c] <= acc_nxt[CW-1:0];
        end else begin
          q_r[c] <= acc_nxt[CW-1:0];
        end
      end
      if (cmd.phase_dot && cmd.half && c == rqfh_pkg::LAST_COMP) begin
        case (cmd.grp)
          rqfh_pkg::GRP_DET: det_r <= acc_nxt;
          rqfh_pkg::GRP_UN:  un_r  <= acc_nxt;
          rqfh_pkg::GRP_VN:  vn_r  <= acc_nxt;
          default:           tn_r  <= acc_nxt;
        endcase
      end
    end
    if (cmd.dec && hit) begin
      best_r <= rd_id_r;
    end
    if (cmd.fin) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      dup_r        <= 1'b0;
      free_found_r <= 1'b0;
      found_r      <= 1'b0;
      best_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cmd.latch) begin
        dup_r        <= 1'b0;
        free_found_r <= 1'b0;
        found_r      <= 1'b0;
        best_v_r     <= 1'b0;
      end
      if (cmd.chk) begin
        if (req_r.req_type == rqfh_pkg::REQ_ADD) begin
          if (is_match) begin
            dup_r <= 1'b1;
          end
          if (!valid_r[idx]) begin
            free_found_r <= 1'b1;
          end
        end
        if (req_r.req_type == rqfh_pkg::REQ_REMOVE && is_match) begin
          valid_r[idx] <= 1'b0;
          found_r      <= 1'b1;
        end
      end
      if (cmd.dec && hit) begin
        best_v_r <= 1'b1;
      end
      if (cmd.fin) begin
        if (req_r.req_type == rqfh_pkg::REQ_CLEAR) begin
          valid_r <= '0;
        end
        if (req_r.req_type == rqfh_pkg::REQ_ADD && !dup_r && free_found_r) begin
          valid_r[free_idx_r] <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/ray_quad_first_hit_table.sv =====
// Table of up to MAX_SCREENS parallelogram screens with a ray query.
// A transaction is accepted at a rising edge with start high and busy low;
// in_req carries the request type, the screen id and three coordinate
// vectors. Each transaction produces exactly one result on out_res, marked
// by out_valid for one cycle, in the first cycle in which busy is low again.
// Every request passes through acceptance, a scan of the table slots in order,
// and a step that forms the result. A clear skips the scan. A query adds, for
// each slot that is actually tested, a step that forms the edge vectors, a run
// on the single shared multiply-accumulate unit for the cross products and
// the split-width dot products, and a step that decides.
// At most one transaction is in progress at a time.
// Reset empties the table at once and drops any transaction in progress.
// The receiver cannot stall; the result must be taken in its strobe cycle.
`default_nettype none
module ray_quad_first_hit_table #(
  parameter int MAX_SCREENS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire rqfh_pkg::req_t in_req,
  output logic                out_valid,
  output rqfh_pkg::res_t      out_res
);

  localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

  rqfh_pkg::cmd_t   cmd;
  rqfh_pkg::sts_t   sts;
  logic [IDX_W-1:0] idx;

  rqfh_ctrl #(
    .MAX_SCREENS(MAX_SCREENS),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .sts(sts),
    .cmd(cmd),
    .idx(idx)
  );

  rqfh_dp #(
    .MAX_SCREENS(MAX_SCREENS),
    .IDX_W(IDX_W)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req),
    .cmd(cmd),
    .idx(idx),
    .sts(sts),
    .out_valid(out_valid),
    .out_res(out_res)
  );

endmodule
`default_nettype wire

// ===== rtl/core/rqfh_checker.sv =====
`default_nettype none
module rqfh_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire rqfh_pkg::res_t out_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.success |-> out_res.status == rqfh_pkg::ST_OK)
    else $error("success with a non-ok status");

  a_hit_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.hit_id != 8'd0 |-> out_res.success)
    else $error("hit id reported without success");

endmodule

bind ray_quad_first_hit_table rqfh_checker u_checker (.*);
`default_nettype wire

// ===== dv/ray_quad_first_hit_checker.sv =====
module ray_quad_first_hit_checker
  import rqfh_pkg::*;
#(
  parameter int MAX_SCREENS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t in_req,
  input  wire logic out_valid,
  input  wire res_t out_res,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  logic                      tbl_valid [MAX_SCREENS];
  logic [7:0]                tbl_id    [MAX_SCREENS];
  logic signed [COORD_W-1:0] tbl_coord [MAX_SCREENS][9];
  res_t                      expected_results[$];
  int                        mismatch_count;

  assign fail_count = mismatch_count;

  function automatic bit screen_is_hit(int slot, req_t rq);
    wide_t o[3], d[3], ll[3], ea[3], eb[3], s[3], p[3], q[3];
    wide_t det, un, vn, tn;
    o[0] = rq.vec_a_x; o[1] = rq.vec_a_y; o[2] = rq.vec_a_z;
    d[0] = rq.vec_b_x; d[1] = rq.vec_b_y; d[2] = rq.vec_b_z;
    for (int k = 0; k < 3; k++) begin
      ll[k] = tbl_coord[slot][k];
      ea[k] = wide_t'(tbl_coord[slot][3+k]) - ll[k];
      eb[k] = wide_t'(tbl_coord[slot][6+k]) - ll[k];
      s[k]  = o[k] - ll[k];
    end
    p[0] = d[1]*eb[2] - d[2]*eb[1];
    p[1] = d[2]*eb[0] - d[0]*eb[2];
    p[2] = d[0]*eb[1] - d[1]*eb[0];
    q[0] = s[1]*ea[2] - s[2]*ea[1];
    q[1] = s[2]*ea[0] - s[0]*ea[2];
    q[2] = s[0]*ea[1] - s[1]*ea[0];
    det = ea[0]*p[0] + ea[1]*p[1] + ea[2]*p[2];
    if (det == 0) return 0;
    un = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    tn = eb[0]*q[0] + eb[1]*q[1] + eb[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (tn < 0) return 0;
    if (un < 0 || un > det) return 0;
    if (vn < 0 || vn > det) return 0;
    return 1;
  endfunction

  function automatic res_t apply_request(req_t rq);
    res_t r;
    int   free_slot;
    bit   dup;
    int   best;
    r = '0;
    case (req_type_t'(rq.req_type))
      REQ_ADD: begin
        free_slot = -1;
        dup = 0;
        for (int i = 0; i < MAX_SCREENS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == rq.screen_id) dup = 1;
          if (!tbl_valid[i] && free_slot < 0) free_slot = i;
        end
        if (dup) begin
          r.status = ST_DUPLICATE;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[free_slot] = 1;
          tbl_id[free_slot] = rq.screen_id;
          tbl_coord[free_slot] = '{rq.vec_a_x, rq.vec_a_y, rq.vec_a_z,
                                   rq.vec_b_x, rq.vec_b_y, rq.vec_b_z,
                                   rq.vec_c_x, rq.vec_c_y, rq.vec_c_z};
          r.success = 1;
          r.status = ST_OK;
        end
      end
      REQ_REMOVE: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < MAX_SCREENS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == rq.screen_id) begin
            tbl_valid[i] = 0;
            r.success = 1;
            r.status = ST_OK;
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < MAX_SCREENS; i++) tbl_valid[i] = 0;
        r.success = 1;
        r.status = ST_OK;
      end
      default: begin
        best = -1;
        for (int i = 0; i < MAX_SCREENS; i++) begin
          if (tbl_valid[i] && (best < 0 || tbl_id[i] < best)) begin
            if (screen_is_hit(i, rq)) best = tbl_id[i];
          end
        end
        if (best >= 0) begin
          r.success = 1;
          r.hit_id = best[7:0];
          r.status = ST_OK;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SCREENS; i++) tbl_valid[i] = 0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result %p", out_res);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_res.success !== exp_res.success || out_res.hit_id !== exp_res.hit_id ||
              out_res.status !== exp_res.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected %p actual %p", exp_res, out_res);
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(in_req));
    end
    pending_count = expected_results.size();
  end
endmodule

// ===== dv/tb_ray_quad_first_hit_table.sv =====
module tb_ray_quad_first_hit_table;
  import rqfh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SCREENS = 8;
  localparam int SCALE = 65536;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  res_t out_res;
  int   fail_count;
  int   pending_count;
  int   quiet_lo;
  int   quiet_hi;
  int   sent;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ray_quad_first_hit_table #(.MAX_SCREENS(MAX_SCREENS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  ray_quad_first_hit_checker #(.MAX_SCREENS(MAX_SCREENS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'((signed'($urandom_range(0, 8)) - 4) * SCALE);
      1: return 24'($urandom);
      2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
      default: return 24'((signed'($urandom_range(0, 64)) - 32) * (SCALE / 4));
    endcase
  endfunction

  function automatic req_t make_req(req_type_t t, int id,
                                    int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    req_t r;
    r.req_type = t;
    r.screen_id = id[7:0];
    r.vec_a_x = 24'(ax); r.vec_a_y = 24'(ay); r.vec_a_z = 24'(az);
    r.vec_b_x = 24'(bx); r.vec_b_y = 24'(by); r.vec_b_z = 24'(bz);
    r.vec_c_x = 24'(cx); r.vec_c_y = 24'(cy); r.vec_c_z = 24'(cz);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   roll;
    r = '0;
    r.screen_id = 8'($urandom);
    r.vec_a_x = rand_coord(); r.vec_a_y = rand_coord(); r.vec_a_z = rand_coord();
    r.vec_b_x = rand_coord(); r.vec_b_y = rand_coord(); r.vec_b_z = rand_coord();
    r.vec_c_x = rand_coord(); r.vec_c_y = rand_coord(); r.vec_c_z = rand_coord();
    roll = $urandom_range(0, 99);
    if (roll < 30) r.req_type = REQ_ADD;
    else if (roll < 45) r.req_type = REQ_REMOVE;
    else if (roll < 48) r.req_type = REQ_CLEAR;
    else r.req_type = REQ_QUERY;
    if ($urandom_range(0, 3) != 0) r.screen_id = 8'($urandom_range(0, 11));
    if (r.req_type == REQ_QUERY && $urandom_range(0, 1)) begin
      r.vec_a_x = 24'((signed'($urandom_range(0, 6)) - 3) * SCALE);
      r.vec_a_y = 24'((signed'($urandom_range(0, 6)) - 3) * SCALE);
      r.vec_a_z = 24'((signed'($urandom_range(0, 6)) - 3) * SCALE);
    end
    return r;
  endfunction

  task automatic send(req_t r, bit allow_idle);
    bit taken;
    taken = 1'b0;
    while (allow_idle && $urandom_range(0, 99) < 12) @(posedge clk);
    start  <= 1;
    in_req <= r;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    start <= 0;
    sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_ADD, 0, 0, 0, 0, SCALE, 0, 0, 0, SCALE, 0), 0);
    send(make_req(REQ_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, 0, 0, -SCALE, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, SCALE, SCALE, -SCALE, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, 0, 0, -SCALE, SCALE, 0, 0, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, 0, 0, SCALE, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_ADD, 255, 0, 0, 0, SCALE, 0, 0, 0, 0, SCALE), 0);
    send(make_req(REQ_QUERY, 0, SCALE/2, -SCALE, SCALE/2, 0, SCALE, 0, 0, 0, 0), 0);
    send(make_req(REQ_ADD, 9, 0, 0, 0, SCALE, SCALE, 0, 2*SCALE, 2*SCALE, 0), 0);
    send(make_req(REQ_ADD, 3, 24'h800000, 24'h800000, 24'h800000,
                  24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff),
         0);
    for (int i = 10; i < 16; i++)
      send(make_req(REQ_ADD, i, 0, 0, i*SCALE, SCALE, 0, i*SCALE, 0, SCALE, i*SCALE), 0);
    send(make_req(REQ_QUERY, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                  24'h800000, 24'h800000, 24'h800000, 0, 0, 0), 0);
    send(make_req(REQ_REMOVE, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send(make_req(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, SCALE/2, SCALE/2, -SCALE, 0, 0, SCALE, 0, 0, 0), 0);
    send(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send(make_req(REQ_QUERY, 0, 0, 0, -SCALE, 0, 0, SCALE, 0, 0, 0), 0);
    for (int n = 0; n < 1100; n++) begin
      quiet_lo = 400;
      quiet_hi = 650;
      send(rand_req(), !(n >= quiet_lo && n < quiet_hi));
    end
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
